// ===== rtl/aes128_block_encrypt_defines.svh =====
// Assertion macros shared by the AES-128 encryption RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aes_pkg.sv =====
// Package for the AES-128 encryption block: payload types, round constants,
// S-box table and GF(2^8) helpers. No dependencies.
`timescale 1ns / 1ps

package aes_pkg;

  localparam int NumRounds  = 10;
  localparam int BlockBytes = 16;

  localparam logic [0:0] CfgKeyHigh = 1'b0;
  localparam logic [0:0] CfgKeyLow  = 1'b1;

  typedef struct packed {
    logic [63:0] plaintext_high;
    logic [63:0] plaintext_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;
  } aes_out_t;

  typedef logic [127:0] aes_block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a block sits at bits 127-8n .. 120-8n.
  function automatic logic [7:0] get_byte(input aes_block_t b, input int n);
    get_byte = b[127 - 8 * n -: 8];
  endfunction

endpackage

// ===== rtl/aes_round.sv =====
// One AES round stage with the matching key expansion step, registered.
// Depends on aes_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "aes128_block_encrypt_defines.svh"

module aes_round
  import aes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_in,
  input  logic       last_round,
  input  logic [7:0] rcon,
  input  aes_block_t state_in,
  input  aes_block_t key_in,
  output logic       valid_out,
  output aes_block_t state_out,
  output aes_block_t key_out
);

  logic       valid_r;
  aes_block_t state_r, state_nxt;
  aes_block_t key_r, key_nxt;
  aes_block_t sub_shift;
  aes_block_t mixed;

  // Next round key from the key of the previous round.
  always_comb begin
    logic [31:0] w3, t;
    w3 = key_in[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    key_nxt[127:96] = key_in[127:96] ^ t;
    key_nxt[95:64]  = key_in[95:64] ^ key_nxt[127:96];
    key_nxt[63:32]  = key_in[63:32] ^ key_nxt[95:64];
    key_nxt[31:0]   = key_in[31:0]  ^ key_nxt[63:32];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_shift[127 - 8 * (r + 4 * c) -: 8] =
          SBOX[get_byte(state_in, r + 4 * ((c + r) % 4))];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0  = get_byte(sub_shift, 4 * c);
      a1  = get_byte(sub_shift, 4 * c + 1);
      a2  = get_byte(sub_shift, 4 * c + 2);
      a3  = get_byte(sub_shift, 4 * c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      mixed[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      mixed[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      mixed[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
  end

  assign state_nxt = (last_round ? sub_shift : mixed) ^ key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign valid_out = valid_r;
  assign state_out = state_r;
  assign key_out   = key_r;

  `AES_ASSERT_NEXT(a_valid_follows, clk, rst_n, valid_in, valid_out, "round lost a request")
  `AES_ASSERT_NEXT(a_no_spurious, clk, rst_n, !valid_in, !valid_out, "round invented a request")
  `AES_ASSERT_NEXT(a_key_step, clk, rst_n, valid_in, key_out[127:96] == $past(key_nxt[127:96]),
                   "round key not carried")

endmodule

// ===== rtl/aes128_block_encrypt.sv =====
// Top level of the AES-128 encryption pipeline: key registers, whitening and
// ten round stages. Depends on aes_pkg, aes_round and the macro header.
`timescale 1ns / 1ps
`include "aes128_block_encrypt_defines.svh"

// A request is taken in every cycle in which start is high; busy is never
// raised. Each ciphertext appears on out_data with out_valid after one
// register for the initial key XOR and one per round stage, ten of them.
// The round keys are expanded alongside the data, so every request uses
// the key as written when it was taken. The receiver cannot stall, so the
// pipeline never holds.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  aes_in_t     in_data,
  output logic        out_valid,
  output aes_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_hi_r, key_lo_r;
  logic        v0_r;
  aes_block_t  st0_r, key0_r;
  logic       [NumRounds:0] vld;
  aes_block_t  st  [NumRounds+1];
  aes_block_t  rk  [NumRounds+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgKeyHigh: key_hi_r <= cfg_data;
        CfgKeyLow:  key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    st0_r  <= {in_data.plaintext_high, in_data.plaintext_low} ^ {key_hi_r, key_lo_r};
    key0_r <= {key_hi_r, key_lo_r};
  end

  assign vld[0] = v0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = key0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .valid_in   (vld[g]),
      .last_round (g == NumRounds - 1),
      .rcon       (RCON[g]),
      .state_in   (st[g]),
      .key_in     (rk[g]),
      .valid_out  (vld[g+1]),
      .state_out  (st[g+1]),
      .key_out    (rk[g+1])
    );
  end

  assign out_valid = vld[NumRounds];
  assign out_data  = st[NumRounds];

  `AES_ASSERT_NEXT(a_start_enters, clk, rst_n, start, vld[0], "request dropped at entry")
  `AES_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy && cfg_ready, "block stalled")
  `AES_ASSERT_NEXT(a_idle_out, clk, rst_n, !vld[NumRounds-1], !out_valid, "result invented")

endmodule
